@@ rtl/core/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and codes of the contiguous segment allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned AddrBits    = 16;
  localparam logic [16:0] CapLimit    = 17'(64'd1 << AddrBits);
  localparam logic [15:0] CapReset    = 16'd1024;

  localparam logic [1:0] FuncAlloc   = 2'd0;
  localparam logic [1:0] FuncFree    = 2'd1;
  localparam logic [1:0] FuncCompact = 2'd2;

  localparam logic [1:0] ModeFirst = 2'd0;
  localparam logic [1:0] ModeBest  = 2'd1;
  localparam logic [1:0] ModeWorst = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StBadLen   = 3'd4;
  localparam logic [2:0] StEmpty    = 3'd5;

  localparam logic CfgFitMode  = 1'b0;
  localparam logic CfgCapacity = 1'b1;

  typedef struct packed {
    logic [15:0] seg_first;
    logic [15:0] seg_last;
  } seg_t;

  typedef struct packed {
    logic        take;
    logic [16:0] size;
  } fit_t;

endpackage

`default_nettype wire

@@ rtl/core/contiguous_segment_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_segment_allocator
// Segment table with first, best or worst fit allocation, free and compact.
// ----------------------------------------------------------------------------
// A request is a transfer on start while busy is low. The table lives in a
// RAM with one registered read port, so every table entry visited takes a
// read state and then an evaluate or write state. An allocate scans up to
// count+1 holes and then shifts the entries above the chosen hole; a free
// scans up to the matching entry and shifts the entries above it; a compact
// emits one result per segment. Results appear for one cycle on valid_o and
// cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = csa_pkg::MaxSegments
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] length_i,
  input  wire logic [15:0] address_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [15:0]      start_address_o,
  output logic [15:0]      old_address_o,
  output logic [15:0]      segment_length_o,
  output logic             last_o
);

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_EV, S_A_SH, S_A_WR, S_F_RD, S_F_EV, S_F_SH, S_F_WR,
    S_C_RD, S_C_EV
  } state_e;

  state_e         state_q;
  logic [1:0]     mode_q, req_mode_q;
  logic [15:0]    cap_q;
  logic [CW-1:0]  count_q, k_q, pick_q;
  logic [15:0]    len_q, addr_q, pick_lo_q, cur_q;
  logic [16:0]    lo_q, best_q;
  logic           have_q;

  logic           valid_q, last_q;
  logic [2:0]     status_q;
  logic [15:0]    sa_q, oa_q, sl_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  csa_pkg::seg_t  ram_wdata, ram_rdata;
  csa_pkg::fit_t  fit;
  logic [16:0]    cap_eff, hi;
  logic [15:0]    ent_len;

  assign cap_eff = ({1'b0, cap_q} > csa_pkg::CapLimit) ? csa_pkg::CapLimit
                                                         : {1'b0, cap_q};
  assign hi      = (k_q == count_q) ? cap_eff : {1'b0, ram_rdata.seg_first};
  assign ent_len = ram_rdata.seg_last - ram_rdata.seg_first + 16'd1;

  csa_fit_unit u_fit (
    .lo_i   (lo_q),
    .hi_i   (hi),
    .len_i  (len_q),
    .mode_i (req_mode_q),
    .have_i (have_q),
    .best_i (best_q),
    .fit_o  (fit)
  );

  csa_ram #(
    .Width ($bits(csa_pkg::seg_t)),
    .Depth (MAX_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = k_q[AW-1:0];
    case (state_q)
      S_A_SH: begin
        ram_raddr = AW'(k_q - CW'(1));
        if (k_q <= pick_q) begin
          ram_we    = 1'b1;
          ram_waddr = pick_q[AW-1:0];
          ram_wdata.seg_first = pick_lo_q;
          ram_wdata.seg_last  = pick_lo_q + len_q - 16'd1;
        end
      end
      S_A_WR, S_F_WR: ram_we = 1'b1;
      S_F_SH: ram_raddr = AW'(k_q + CW'(1));
      S_C_EV: begin
        ram_we = 1'b1;
        ram_wdata.seg_first = cur_q;
        ram_wdata.seg_last  = cur_q + ent_len - 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= csa_pkg::ModeFirst;
      cap_q      <= csa_pkg::CapReset;
      count_q    <= '0;
      valid_q    <= 1'b0;
      req_mode_q <= csa_pkg::ModeFirst;
      k_q        <= '0;
      pick_q     <= '0;
      have_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b1;
      oa_q    <= '0;
      sa_q    <= '0;
      sl_q    <= '0;
      if (cfg_we_i) begin
        if (cfg_idx_i == csa_pkg::CfgFitMode) begin
          mode_q <= cfg_wdata_i[1:0];
        end else begin
          cap_q <= cfg_wdata_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            len_q      <= length_i;
            addr_q     <= address_i;
            req_mode_q <= mode_q;
            k_q        <= '0;
            lo_q       <= '0;
            have_q     <= 1'b0;
            cur_q      <= '0;
            case (func_i)
              csa_pkg::FuncAlloc: begin
                if (length_i == 16'd0) begin
                  valid_q <= 1'b1;
                  status_q <= csa_pkg::StBadLen;
                end else if (count_q == CW'(MAX_SEGMENTS)) begin
                  valid_q <= 1'b1;
                  status_q <= csa_pkg::StFull;
                end else if (mode_q != csa_pkg::ModeFirst &&
                             mode_q != csa_pkg::ModeBest &&
                             mode_q != csa_pkg::ModeWorst) begin
                  valid_q <= 1'b1;
                  status_q <= csa_pkg::StNoSpace;
                end else begin
                  state_q <= S_A_RD;
                end
              end
              csa_pkg::FuncFree, csa_pkg::FuncCompact: begin
                if (count_q == '0) begin
                  valid_q <= 1'b1;
                  status_q <= csa_pkg::StEmpty;
                end else begin
                  state_q <= (func_i == csa_pkg::FuncFree) ? S_F_RD : S_C_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_A_RD: state_q <= S_A_EV;
        S_A_EV: begin
          if (fit.take) begin
            have_q    <= 1'b1;
            best_q    <= fit.size;
            pick_q    <= k_q;
            pick_lo_q <= lo_q[15:0];
          end
          lo_q <= {1'b0, ram_rdata.seg_last} + 17'd1;
          if ((fit.take && req_mode_q == csa_pkg::ModeFirst) ||
              (k_q == count_q && (have_q || fit.take))) begin
            k_q     <= count_q;
            state_q <= S_A_SH;
          end else if (k_q == count_q) begin
            valid_q  <= 1'b1;
            status_q <= csa_pkg::StNoSpace;
            state_q  <= S_IDLE;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_A_RD;
          end
        end
        S_A_SH: begin
          if (k_q > pick_q) begin
            state_q <= S_A_WR;
          end else begin
            count_q  <= count_q + CW'(1);
            valid_q  <= 1'b1;
            status_q <= csa_pkg::StOk;
            sa_q     <= pick_lo_q;
            sl_q     <= len_q;
            state_q  <= S_IDLE;
          end
        end
        S_A_WR: begin
          k_q     <= k_q - CW'(1);
          state_q <= S_A_SH;
        end
        S_F_RD: state_q <= S_F_EV;
        S_F_EV: begin
          if (ram_rdata.seg_first == addr_q) begin
            len_q   <= ent_len;
            state_q <= S_F_SH;
          end else if (k_q + CW'(1) == count_q) begin
            valid_q  <= 1'b1;
            status_q <= csa_pkg::StNotFound;
            state_q  <= S_IDLE;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_F_RD;
          end
        end
        S_F_SH: begin
          if (k_q + CW'(1) < count_q) begin
            state_q <= S_F_WR;
          end else begin
            count_q  <= count_q - CW'(1);
            valid_q  <= 1'b1;
            status_q <= csa_pkg::StOk;
            sa_q     <= addr_q;
            sl_q     <= len_q;
            state_q  <= S_IDLE;
          end
        end
        S_F_WR: begin
          k_q     <= k_q + CW'(1);
          state_q <= S_F_SH;
        end
        S_C_RD: state_q <= S_C_EV;
        S_C_EV: begin
          valid_q  <= 1'b1;
          status_q <= csa_pkg::StOk;
          sa_q     <= cur_q;
          oa_q     <= ram_rdata.seg_first;
          sl_q     <= ent_len;
          last_q   <= (k_q + CW'(1) == count_q);
          cur_q    <= cur_q + ent_len;
          k_q      <= k_q + CW'(1);
          state_q  <= (k_q + CW'(1) == count_q) ? S_IDLE : S_C_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign start_address_o  = sa_q;
  assign old_address_o    = oa_q;
  assign segment_length_o = sl_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

@@ rtl/core/csa_ram.sv @@
// ----------------------------------------------------------------------------
// csa_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/csa_fit_unit.sv @@
// ----------------------------------------------------------------------------
// csa_fit_unit
// Shared hole evaluator: hole size, fit test and fit-policy compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csa_fit_unit (
  input  wire logic [16:0] lo_i,
  input  wire logic [16:0] hi_i,
  input  wire logic [15:0] len_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        have_i,
  input  wire logic [16:0] best_i,
  output csa_pkg::fit_t    fit_o
);

  logic [17:0] diff;
  logic        fits;

  assign diff = {1'b0, hi_i} - {1'b0, lo_i};
  assign fits = !diff[17] && (diff[16:0] >= {1'b0, len_i});

  always_comb begin
    fit_o.size = diff[16:0];
    fit_o.take = 1'b0;
    if (fits) begin
      if (!have_i) begin
        fit_o.take = 1'b1;
      end else if (mode_i == csa_pkg::ModeBest) begin
        fit_o.take = diff[16:0] < best_i;
      end else if (mode_i == csa_pkg::ModeWorst) begin
        fit_o.take = diff[16:0] > best_i;
      end
    end
  end

endmodule

`default_nettype wire
